[rtl/rmth_pkg.sv]
// Package for the running median block: field widths, sequencer op codes
// and the controller state type. No dependencies.
`default_nettype none
package rmth_pkg;

    localparam int SAMPLE_W = 32;
    localparam int MEDIAN_W = 33;
    localparam int COUNT_W  = 11;

    // Heap operations queued for one sample.
    typedef enum logic [2:0] {
        OP_NONE,
        OP_PUSH_LO_S,   // push the sample into the lower heap
        OP_PUSH_UP_S,   // push the sample into the upper heap
        OP_POP_LO,      // pop the lower heap, keep its top as the moved value
        OP_POP_UP,      // pop the upper heap, keep its top as the moved value
        OP_PUSH_LO_T,   // push the moved value into the lower heap
        OP_PUSH_UP_T    // push the moved value into the upper heap
    } op_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_PUSH_CHK,
        S_PUSH_CMP,
        S_POP_V,
        S_POP_CHK,
        S_POP_C1,
        S_POP_C2,
        S_POP_CMP,
        S_DONE
    } state_t;

endpackage
`default_nettype wire

[rtl/rmth_in_if.sv]
// Input channel of the running median block: one sample per transaction.
// Depends on rmth_pkg for the field width.
`default_nettype none
interface rmth_in_if import rmth_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface
`default_nettype wire

[rtl/rmth_out_if.sv]
// Output channel of the running median block: one result per transaction.
// Depends on rmth_pkg for the field widths.
`default_nettype none
interface rmth_out_if import rmth_pkg::*;;
    logic                       valid;
    logic                       ready;
    logic signed [MEDIAN_W-1:0] median_twice;
    logic [COUNT_W-1:0]         stored_count;
    logic                       dropped;

    modport source (output valid, output median_twice, output stored_count,
                    output dropped, input ready);
    modport sink   (input valid, input median_twice, input stored_count,
                    input dropped, output ready);
endinterface
`default_nettype wire

[rtl/running_median_two_heaps.sv]
// Running median over two heaps held in synchronous memories.
// Depends on rmth_pkg, rmth_in_if and rmth_out_if.
//
// Usage: each transaction on the samples channel carries one signed 32-bit
// sample. For every sample exactly one transaction leaves on the results
// channel: twice the median of all stored samples (33 bits, signed), the
// number of stored samples and a dropped flag. Samples arriving once
// CAPACITY samples are stored are not stored; their result reports the
// unchanged store with dropped set.
// The lower half sits in a max-heap and the upper half in a min-heap, each
// in its own memory with one write and one registered read port. The tops
// of both heaps are mirrored in registers, so the median needs no read.
// One sample runs up to three heap operations on a shared sift sequencer.
// A push climbs each level through S_PUSH_CHK and S_PUSH_CMP, a pop
// descends each level through S_POP_CHK, S_POP_C1, S_POP_C2 (only with a
// second child) and S_POP_CMP, all paced by the registered memory read.
// One sample is in work at a time; the next sample can be taken once the
// previous result sits in the output register, even if not yet taken.
// If the receiver stalls with a result still pending, the next sample
// finishes its work and then waits until the output register frees up.
// Reset clears the heap sizes; memory contents need no clearing because
// only entries below the heap sizes are ever read.
`default_nettype none
module running_median_two_heaps
    import rmth_pkg::*;
#(
    parameter int CAPACITY = 1024
) (
    input  wire         clk,
    input  wire         rst_n,
    rmth_in_if.sink     samples,
    rmth_out_if.source  results
);

    localparam int HEAP_DEPTH = CAPACITY / 2 + 2;
    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam int TW = CW + 1;

    typedef logic signed [SAMPLE_W-1:0] word_t;

    // Heap memories.
    word_t lower_mem [HEAP_DEPTH];
    word_t upper_mem [HEAP_DEPTH];

    state_t state_reg, state_next;
    op_t    op_q_reg [3];
    op_t    op_q_next [3];
    logic [CW-1:0] cnt_lo_reg, cnt_lo_next;
    logic [CW-1:0] cnt_up_reg, cnt_up_next;
    logic [CW-1:0] idx_reg, idx_next;      // current hole position
    logic [CW-1:0] n_reg, n_next;          // heap size during a pop
    logic [TW-1:0] bidx_reg, bidx_next;    // chosen child position
    logic          sel_reg, sel_next;      // 1 selects the upper heap
    logic          drop_reg, drop_next;
    word_t         sample_reg, sample_next;
    word_t         moved_reg, moved_next;
    word_t         v_reg, v_next;
    word_t         best_reg, best_next;
    word_t         top_lo_reg, top_up_reg;

    logic                       out_valid_reg, out_valid_next;
    logic signed [MEDIAN_W-1:0] out_med_reg, out_med_next;
    logic [COUNT_W-1:0]         out_cnt_reg, out_cnt_next;
    logic                       out_drop_reg, out_drop_next;

    // Memory port controls.
    logic          we;
    logic [AW-1:0] waddr, raddr;
    word_t         wdata;
    word_t         rdata_lo, rdata_up, rdata;

    logic                       accept;
    logic [TW-1:0]              total;
    logic [TW-1:0]              child, child1;
    logic [CW-1:0]              parent;
    logic signed [MEDIAN_W-1:0] median;

    function automatic logic ahead(input word_t a, input word_t b, input logic is_min);
        ahead = is_min ? (a < b) : (a > b);
    endfunction

    assign accept = samples.valid && samples.ready;
    assign samples.ready = (state_reg == S_IDLE);
    assign total = TW'(cnt_lo_reg) + TW'(cnt_up_reg);
    assign child = {1'b0, idx_reg[CW-2:0], 1'b1};
    assign child1 = child + TW'(1);
    assign parent = (idx_reg - CW'(1)) >> 1;
    assign rdata = sel_reg ? rdata_up : rdata_lo;

    // Median from the mirrored heap tops.
    always_comb
    begin
        if (cnt_up_reg > cnt_lo_reg)
            median = MEDIAN_W'(top_up_reg) + MEDIAN_W'(top_up_reg);
        else if (cnt_lo_reg > cnt_up_reg)
            median = MEDIAN_W'(top_lo_reg) + MEDIAN_W'(top_lo_reg);
        else if (cnt_lo_reg == '0)
            median = '0;
        else
            median = MEDIAN_W'(top_up_reg) + MEDIAN_W'(top_lo_reg);
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_LOAD;
            end
            S_LOAD:
            begin
                unique case (op_q_reg[0])
                    OP_NONE:
                        state_next = S_DONE;
                    OP_POP_LO:
                        state_next = (cnt_lo_reg == CW'(1)) ? S_LOAD : S_POP_V;
                    OP_POP_UP:
                        state_next = (cnt_up_reg == CW'(1)) ? S_LOAD : S_POP_V;
                    default:
                        state_next = S_PUSH_CHK;
                endcase
            end
            S_PUSH_CHK:
                state_next = (idx_reg == '0) ? S_LOAD : S_PUSH_CMP;
            S_PUSH_CMP:
                state_next = ahead(v_reg, rdata, sel_reg) ? S_PUSH_CHK : S_LOAD;
            S_POP_V:
                state_next = S_POP_CHK;
            S_POP_CHK:
                state_next = (child >= TW'(n_reg)) ? S_LOAD : S_POP_C1;
            S_POP_C1:
                state_next = (child1 < TW'(n_reg)) ? S_POP_C2 : S_POP_CMP;
            S_POP_C2:
                state_next = S_POP_CMP;
            S_POP_CMP:
                state_next = ahead(best_reg, v_reg, sel_reg) ? S_POP_CHK : S_LOAD;
            S_DONE:
            begin
                if (!out_valid_reg || results.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        op_q_next      = op_q_reg;
        cnt_lo_next    = cnt_lo_reg;
        cnt_up_next    = cnt_up_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        bidx_next      = bidx_reg;
        sel_next       = sel_reg;
        drop_next      = drop_reg;
        sample_next    = sample_reg;
        moved_next     = moved_reg;
        v_next         = v_reg;
        best_next      = best_reg;
        out_valid_next = out_valid_reg && !results.ready;
        out_med_next   = out_med_reg;
        out_cnt_next   = out_cnt_reg;
        out_drop_next  = out_drop_reg;
        we             = 1'b0;
        waddr          = idx_reg[AW-1:0];
        wdata          = v_reg;
        raddr          = parent[AW-1:0];

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sample_next  = samples.sample;
                    drop_next    = 1'b0;
                    op_q_next[0] = OP_NONE;
                    op_q_next[1] = OP_NONE;
                    op_q_next[2] = OP_NONE;
                    if (total >= TW'(CAPACITY))
                        drop_next = 1'b1;
                    else if (cnt_lo_reg == '0 && cnt_up_reg == '0)
                        op_q_next[0] = OP_PUSH_UP_S;
                    else if (cnt_lo_reg == '0)
                    begin
                        if (top_up_reg < samples.sample)
                        begin
                            op_q_next[0] = OP_POP_UP;
                            op_q_next[1] = OP_PUSH_LO_T;
                            op_q_next[2] = OP_PUSH_UP_S;
                        end
                        else
                            op_q_next[0] = OP_PUSH_LO_S;
                    end
                    else if (cnt_up_reg == '0 || samples.sample > top_up_reg)
                    begin
                        op_q_next[0] = OP_PUSH_UP_S;
                        if (cnt_up_reg > cnt_lo_reg)
                        begin
                            op_q_next[1] = OP_POP_UP;
                            op_q_next[2] = OP_PUSH_LO_T;
                        end
                    end
                    else
                    begin
                        op_q_next[0] = OP_PUSH_LO_S;
                        if (cnt_lo_reg > cnt_up_reg)
                        begin
                            op_q_next[1] = OP_POP_LO;
                            op_q_next[2] = OP_PUSH_UP_T;
                        end
                    end
                end
            end
            S_LOAD:
            begin
                op_q_next[0] = op_q_reg[1];
                op_q_next[1] = op_q_reg[2];
                op_q_next[2] = OP_NONE;
                case (op_q_reg[0])
                    OP_PUSH_LO_S, OP_PUSH_LO_T:
                    begin
                        sel_next    = 1'b0;
                        idx_next    = cnt_lo_reg;
                        cnt_lo_next = cnt_lo_reg + CW'(1);
                        v_next      = (op_q_reg[0] == OP_PUSH_LO_S) ? sample_reg : moved_reg;
                    end
                    OP_PUSH_UP_S, OP_PUSH_UP_T:
                    begin
                        sel_next    = 1'b1;
                        idx_next    = cnt_up_reg;
                        cnt_up_next = cnt_up_reg + CW'(1);
                        v_next      = (op_q_reg[0] == OP_PUSH_UP_S) ? sample_reg : moved_reg;
                    end
                    OP_POP_LO:
                    begin
                        sel_next    = 1'b0;
                        moved_next  = top_lo_reg;
                        n_next      = cnt_lo_reg - CW'(1);
                        cnt_lo_next = cnt_lo_reg - CW'(1);
                        raddr       = n_next[AW-1:0];
                    end
                    OP_POP_UP:
                    begin
                        sel_next    = 1'b1;
                        moved_next  = top_up_reg;
                        n_next      = cnt_up_reg - CW'(1);
                        cnt_up_next = cnt_up_reg - CW'(1);
                        raddr       = n_next[AW-1:0];
                    end
                    default:
                    begin
                        out_valid_next = 1'b1;
                    end
                endcase
                if (op_q_reg[0] == OP_NONE)
                    out_valid_next = out_valid_reg && !results.ready;
            end
            S_PUSH_CHK:
            begin
                if (idx_reg == '0)
                    we = 1'b1;
            end
            S_PUSH_CMP:
            begin
                we = 1'b1;
                if (ahead(v_reg, rdata, sel_reg))
                begin
                    wdata    = rdata;
                    idx_next = parent;
                end
            end
            S_POP_V:
            begin
                v_next   = rdata;
                idx_next = '0;
            end
            S_POP_CHK:
            begin
                raddr = child[AW-1:0];
                if (child >= TW'(n_reg))
                    we = 1'b1;
            end
            S_POP_C1:
            begin
                best_next = rdata;
                bidx_next = child;
                raddr     = child1[AW-1:0];
            end
            S_POP_C2:
            begin
                if (ahead(rdata, best_reg, sel_reg))
                begin
                    best_next = rdata;
                    bidx_next = child1;
                end
            end
            S_POP_CMP:
            begin
                we = 1'b1;
                if (ahead(best_reg, v_reg, sel_reg))
                begin
                    wdata    = best_reg;
                    idx_next = bidx_reg[CW-1:0];
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || results.ready)
                begin
                    out_valid_next = 1'b1;
                    out_med_next   = median;
                    out_cnt_next   = COUNT_W'(total);
                    out_drop_next  = drop_reg;
                end
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Heap memories: one write and one registered read per cycle each.
    always_ff @(posedge clk)
    begin
        if (we && !sel_reg)
            lower_mem[waddr] <= wdata;
        if (we && sel_reg)
            upper_mem[waddr] <= wdata;
        rdata_lo <= lower_mem[raddr];
        rdata_up <= upper_mem[raddr];
    end

    // Mirrors of the heap tops, updated on every write to the root.
    always_ff @(posedge clk)
    begin
        if (we && waddr == '0 && !sel_reg)
            top_lo_reg <= wdata;
        if (we && waddr == '0 && sel_reg)
            top_up_reg <= wdata;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_q_reg[0]   <= OP_NONE;
            op_q_reg[1]   <= OP_NONE;
            op_q_reg[2]   <= OP_NONE;
            cnt_lo_reg    <= '0;
            cnt_up_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_q_reg      <= op_q_next;
            cnt_lo_reg    <= cnt_lo_next;
            cnt_up_reg    <= cnt_up_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg      <= idx_next;
        n_reg        <= n_next;
        bidx_reg     <= bidx_next;
        sel_reg      <= sel_next;
        drop_reg     <= drop_next;
        sample_reg   <= sample_next;
        moved_reg    <= moved_next;
        v_reg        <= v_next;
        best_reg     <= best_next;
        out_med_reg  <= out_med_next;
        out_cnt_reg  <= out_cnt_next;
        out_drop_reg <= out_drop_next;
    end

    assign results.valid        = out_valid_reg;
    assign results.median_twice = out_med_reg;
    assign results.stored_count = out_cnt_reg;
    assign results.dropped      = out_drop_reg;

endmodule
`default_nettype wire
